@@ design/mwm_pkg.sv @@
// Shared constants, codes and types for the maze wall map updater.
`default_nettype none

package mwm_pkg;

   localparam int BoardSizeDefault = 16;
   localparam int LevelW           = 12;
   localparam int CellW            = 8;
   localparam int CoordW           = 4;
   localparam int OpW              = 2;
   localparam int DirW             = 2;
   localparam int CsrIdxW          = 2;
   localparam int SlotW            = 2;

   localparam logic [CellW-1:0]  StartCell      = 8'hEE;
   localparam logic [LevelW-1:0] ThresholdReset = 12'd2048;

   localparam logic [OpW-1:0] OpUpdate = 2'd0;
   localparam logic [OpW-1:0] OpPlug   = 2'd1;

   localparam logic [CsrIdxW-1:0] RegFrontThr = 2'd0;
   localparam logic [CsrIdxW-1:0] RegRightThr = 2'd1;
   localparam logic [CsrIdxW-1:0] RegLeftThr  = 2'd2;

   localparam logic [DirW-1:0] DirN = 2'd0;
   localparam logic [DirW-1:0] DirE = 2'd1;
   localparam logic [DirW-1:0] DirS = 2'd2;
   localparam logic [DirW-1:0] DirW_ = 2'd3;

   localparam logic [SlotW-1:0] SlotCenter = 2'd0;
   localparam logic [SlotW-1:0] SlotFront  = 2'd1;
   localparam logic [SlotW-1:0] SlotRight  = 2'd2;
   localparam logic [SlotW-1:0] SlotLeft   = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ0,
      ST_READ1,
      ST_READ2,
      ST_READ3,
      ST_WRITE3,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic             clear_en;
      logic             accept;
      logic             rd_en;
      logic [SlotW-1:0] rd_slot;
      logic             wr_en;
      logic [SlotW-1:0] wr_slot;
      logic             rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic off_board;
      logic is_update;
      logic is_plug;
   } dp_status_type;

endpackage

`default_nettype wire

@@ design/mwm_ctrl.sv @@
// Controller state machine: clearing pass, cell read-modify-write sequence, result handoff.
`default_nettype none

module mwm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mwm_pkg::dp_cmd_type    cmd,
   input  mwm_pkg::dp_status_type status
);
   import mwm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ0;
         end
         ST_READ0: begin
            state_in = status.off_board ? ST_RESP : ST_READ1;
         end
         ST_READ1: begin
            state_in = (status.is_update || status.is_plug) ? ST_READ2 : ST_RESP;
         end
         ST_READ2: begin
            state_in = status.is_plug ? ST_RESP : ST_READ3;
         end
         ST_READ3: begin
            state_in = ST_WRITE3;
         end
         ST_WRITE3: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_READ0: begin
            cmd.rd_en   = !status.off_board;
            cmd.rd_slot = SlotCenter;
         end
         ST_READ1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_slot = SlotCenter;
            cmd.rd_en   = status.is_update || status.is_plug;
            cmd.rd_slot = SlotFront;
         end
         ST_READ2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_slot = SlotFront;
            cmd.rd_en   = status.is_update;
            cmd.rd_slot = SlotRight;
         end
         ST_READ3: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_slot = SlotRight;
            cmd.rd_en   = 1'b1;
            cmd.rd_slot = SlotLeft;
         end
         ST_WRITE3: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_slot = SlotLeft;
         end
         ST_RESP: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mwm_dp.sv @@
// Datapath: thresholds, latched item, map memory, cell merge logic and result register.
`default_nettype none

module mwm_dp #(
   parameter int BOARD_SIZE = mwm_pkg::BoardSizeDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mwm_pkg::OpW-1:0]       req_opcode,
   input  logic [mwm_pkg::DirW-1:0]      req_heading,
   input  logic [mwm_pkg::LevelW-1:0]    req_front_level,
   input  logic [mwm_pkg::LevelW-1:0]    req_right_level,
   input  logic [mwm_pkg::LevelW-1:0]    req_left_level,
   input  logic [mwm_pkg::CoordW-1:0]    req_col,
   input  logic [mwm_pkg::CoordW-1:0]    req_row,
   input  logic                          csr_wr_en,
   input  logic [mwm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mwm_pkg::LevelW-1:0]    csr_wr_data,
   input  mwm_pkg::dp_cmd_type           cmd,
   output mwm_pkg::dp_status_type        status,
   output logic [mwm_pkg::CellW-1:0]     rsp_cell_byte
);
   import mwm_pkg::*;

   localparam int Depth = BOARD_SIZE * BOARD_SIZE;
   localparam int AW    = $clog2(Depth);
   localparam int XW    = $clog2(BOARD_SIZE) + CoordW;
   localparam int MW    = AW + XW;

   localparam logic [AW-1:0] LastAddr  = AW'(Depth - 1);
   localparam logic [AW-1:0] StartAddr = AW'((BOARD_SIZE - 1) * BOARD_SIZE);
   localparam logic [AW-1:0] RowStep   = AW'(BOARD_SIZE);
   localparam logic [AW-1:0] ColStep   = AW'(1);
   localparam logic [XW-1:0] LastCoord = XW'(BOARD_SIZE - 1);
   localparam logic [XW-1:0] BoardLim  = XW'(BOARD_SIZE);

   logic [LevelW-1:0] front_thr_ff, right_thr_ff, left_thr_ff;
   logic [LevelW-1:0] front_thr_in, right_thr_in, left_thr_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   logic              is_update_ff, is_plug_ff, off_board_ff;
   logic [DirW-1:0]   heading_ff;
   logic [2:0]        wall_ff;
   logic [CoordW-1:0] col_ff, row_ff;
   logic [AW-1:0]     center_ff;
   logic              plug_ok_ff, plug_ok_in;
   logic [CellW-1:0]  result_ff, result_in;
   logic [CellW-1:0]  rsp_byte_ff;
   logic [CellW-1:0]  mem_rd_ff;
   logic [CellW-1:0]  mem [Depth];

   logic [MW-1:0]     addr_sum;
   logic              off_board_in;
   logic [DirW-1:0]   rd_dir, wr_dir;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_wall;
   logic [3:0]        need;
   logic              plug_ok_now;
   logic [CellW-1:0]  center_mask, far_mask, merged;
   logic              slot_we;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CellW-1:0]  mem_wd;

   function automatic logic [CellW-1:0] side_bits(input logic [DirW-1:0] dir,
                                                  input logic wall);
      logic [CellW-1:0] bits;
      bits = CellW'(8'h10 << dir);
      if (wall) bits = bits | CellW'(8'h01 << dir);
      return bits;
   endfunction

   function automatic logic [DirW-1:0] slot_dir(input logic [SlotW-1:0] slot,
                                                input logic [DirW-1:0] head);
      logic [DirW-1:0] dir;
      case (slot)
         SlotRight: dir = DirW'(head + 2'd1);
         SlotLeft:  dir = DirW'(head + 2'd3);
         default:   dir = head;
      endcase
      return dir;
   endfunction

   function automatic logic [AW-1:0] nbr_addr(input logic [DirW-1:0] dir,
                                              input logic [AW-1:0] center);
      logic [AW-1:0] addr;
      case (dir)
         DirN:    addr = center - RowStep;
         DirE:    addr = center + ColStep;
         DirS:    addr = center + RowStep;
         default: addr = center - ColStep;
      endcase
      return addr;
   endfunction

   function automatic logic nbr_ok(input logic [DirW-1:0] dir,
                                   input logic [CoordW-1:0] col,
                                   input logic [CoordW-1:0] row);
      logic ok;
      case (dir)
         DirN:    ok = (row != '0);
         DirE:    ok = (XW'(col) != LastCoord);
         DirS:    ok = (XW'(row) != LastCoord);
         default: ok = (col != '0);
      endcase
      return ok;
   endfunction

   assign addr_sum     = MW'(req_row) * MW'(BOARD_SIZE) + MW'(req_col);
   assign off_board_in = (XW'(req_col) >= BoardLim) || (XW'(req_row) >= BoardLim);

   assign rd_dir  = slot_dir(cmd.rd_slot, heading_ff);
   assign wr_dir  = slot_dir(cmd.wr_slot, heading_ff);
   assign rd_addr = (cmd.rd_slot == SlotCenter) ? center_ff : nbr_addr(rd_dir, center_ff);
   assign wr_addr = (cmd.wr_slot == SlotCenter) ? center_ff : nbr_addr(wr_dir, center_ff);

   always_comb begin
      case (cmd.wr_slot)
         SlotFront: wr_wall = wall_ff[0];
         SlotRight: wr_wall = wall_ff[1];
         SlotLeft:  wr_wall = wall_ff[2];
         default:   wr_wall = 1'b0;
      endcase
   end

   assign need        = ~(4'b0001 << heading_ff);
   assign plug_ok_now = ((mem_rd_ff[3:0] & need) == need);

   always_comb begin
      center_mask = '0;
      if (is_update_ff) begin
         center_mask = side_bits(heading_ff, wall_ff[0])
                     | side_bits(DirW'(heading_ff + 2'd1), wall_ff[1])
                     | side_bits(DirW'(heading_ff + 2'd3), wall_ff[2]);
      end else if (is_plug_ff && plug_ok_now) begin
         center_mask = side_bits(heading_ff, 1'b1);
      end
   end

   assign far_mask = side_bits(DirW'(wr_dir + 2'd2), wr_wall);
   assign merged   = mem_rd_ff | ((cmd.wr_slot == SlotCenter) ? center_mask : far_mask);

   always_comb begin
      if (cmd.wr_slot == SlotCenter) begin
         slot_we = is_update_ff || (is_plug_ff && plug_ok_now);
      end else begin
         slot_we = nbr_ok(wr_dir, col_ff, row_ff)
                 && (is_update_ff || (is_plug_ff && plug_ok_ff));
      end
   end

   assign mem_we = cmd.clear_en || (cmd.wr_en && slot_we);
   assign mem_wa = cmd.clear_en ? clr_addr_ff : wr_addr;
   assign mem_wd = cmd.clear_en ? ((clr_addr_ff == StartAddr) ? StartCell : '0) : merged;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.rd_en) mem_rd_ff <= mem[rd_addr];
   end

   always_comb begin
      front_thr_in = front_thr_ff;
      right_thr_in = right_thr_ff;
      left_thr_in  = left_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            RegFrontThr: front_thr_in = csr_wr_data;
            RegRightThr: right_thr_in = csr_wr_data;
            RegLeftThr:  left_thr_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign clr_addr_in = cmd.clear_en ? clr_addr_ff + ColStep : clr_addr_ff;

   always_comb begin
      result_in  = result_ff;
      plug_ok_in = plug_ok_ff;
      if (cmd.accept) begin
         result_in  = '0;
         plug_ok_in = 1'b0;
      end else if (cmd.wr_en && (cmd.wr_slot == SlotCenter)) begin
         result_in  = merged;
         plug_ok_in = plug_ok_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_thr_ff <= ThresholdReset;
         right_thr_ff <= ThresholdReset;
         left_thr_ff  <= ThresholdReset;
         clr_addr_ff  <= '0;
         is_update_ff <= 1'b0;
         is_plug_ff   <= 1'b0;
         off_board_ff <= 1'b0;
      end else begin
         front_thr_ff <= front_thr_in;
         right_thr_ff <= right_thr_in;
         left_thr_ff  <= left_thr_in;
         clr_addr_ff  <= clr_addr_in;
         if (cmd.accept) begin
            is_update_ff <= (req_opcode == OpUpdate);
            is_plug_ff   <= (req_opcode == OpPlug);
            off_board_ff <= off_board_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         heading_ff <= req_heading;
         wall_ff[0] <= (req_opcode == OpPlug) || (req_front_level > front_thr_ff);
         wall_ff[1] <= (req_right_level > right_thr_ff);
         wall_ff[2] <= (req_left_level > left_thr_ff);
         col_ff     <= req_col;
         row_ff     <= req_row;
         center_ff  <= AW'(addr_sum);
      end
      result_ff  <= result_in;
      plug_ok_ff <= plug_ok_in;
      if (cmd.rsp_load) rsp_byte_ff <= result_ff;
   end

   assign status.clear_last = (clr_addr_ff == LastAddr);
   assign status.off_board  = off_board_ff;
   assign status.is_update  = is_update_ff;
   assign status.is_plug    = is_plug_ff;
   assign rsp_cell_byte     = rsp_byte_ff;

endmodule

`default_nettype wire

@@ design/maze_wall_map_updater_core.sv @@
// Items: an update merges into the center cell and its front, right and left neighbours,
// a plug into the center and front cells; a read reads the center cell; off-board, none.
// One item at a time: req_ready rises again only once the last result is loaded.
// Reset: synchronous, active high; thresholds return to 2048, then a clearing pass writes all
// BOARD_SIZE*BOARD_SIZE map cells (start cell 0xEE) with req_ready low.
// Configuration writes are taken in every cycle, also during the clearing pass.
`default_nettype none

module maze_wall_map_updater_core #(
   parameter int BOARD_SIZE = mwm_pkg::BoardSizeDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mwm_pkg::OpW-1:0]       req_opcode,
   input  logic [mwm_pkg::DirW-1:0]      req_heading,
   input  logic [mwm_pkg::LevelW-1:0]    req_front_level,
   input  logic [mwm_pkg::LevelW-1:0]    req_right_level,
   input  logic [mwm_pkg::LevelW-1:0]    req_left_level,
   input  logic [mwm_pkg::CoordW-1:0]    req_col,
   input  logic [mwm_pkg::CoordW-1:0]    req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwm_pkg::CellW-1:0]     rsp_cell_byte,
   input  logic                          csr_wr_en,
   input  logic [mwm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mwm_pkg::LevelW-1:0]    csr_wr_data
);
   import mwm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mwm_dp #(
      .BOARD_SIZE (BOARD_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_heading     (req_heading),
      .req_front_level (req_front_level),
      .req_right_level (req_right_level),
      .req_left_level  (req_left_level),
      .req_col         (req_col),
      .req_row         (req_row),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_cell_byte   (rsp_cell_byte)
   );

endmodule

`default_nettype wire

@@ design/mwm_checker.sv @@
// Port-level checker for the maze wall map updater and its bind to the top level.
`default_nettype none

module mwm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [mwm_pkg::CellW-1:0] rsp_cell_byte
);
   import mwm_pkg::*;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high in the cycle after an accepted item");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("rsp_valid rose in the cycle after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_byte)))
      else $error("stalled result item dropped or changed");

endmodule

bind maze_wall_map_updater_core mwm_checker u_mwm_checker (.*);

`default_nettype wire
